// ----- design/nhbd_pkg.sv -----
package nhbd_pkg;

   // Name and hash geometry
   localparam int NAME_BYTES  = 8;
   localparam int NAME_BITS   = 8 * NAME_BYTES;
   localparam int WORD_BITS   = 32;
   localparam int MULT_BITS   = 24;
   localparam int PROD_BITS   = WORD_BITS + MULT_BITS;
   localparam logic [MULT_BITS-1:0] MULT_RESET = 24'd15813251;

   // Bucket selection: bits 30..24 of the product
   localparam int BUCKET_LSB  = 24;
   localparam int BUCKET_BITS = 7;
   localparam int BUCKETS     = 1 << BUCKET_BITS;

   // Statistics
   localparam int SQ_BITS            = 32;
   localparam int DISP_BITS          = 39;
   localparam int COUNT_BITS_DEFAULT = 16;

   // Queue between the hashing front end and the counting back end
   localparam int QUEUE_DEPTH    = 4;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_LVL_BITS = QUEUE_PTR_BITS + 1;

   typedef struct packed {
      logic [BUCKET_BITS-1:0] bucket;
      logic                   last_name;
   } nhbd_entry_type;

endpackage

// ----- design/nhbd_ram.sv -----
module nhbd_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/nhbd_front.sv -----
module nhbd_front
   import nhbd_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [NAME_BITS-1:0]      req_name_bytes,
   input  logic                      req_last_name,
   input  logic [MULT_BITS-1:0]      multiplier,
   input  logic [QUEUE_LVL_BITS-1:0] queue_level,
   output logic                      push_valid,
   output nhbd_entry_type            push_entry
);

   localparam int OCC_BITS = QUEUE_LVL_BITS + 1;

   logic                 s1_valid_ff, s1_valid_in;
   logic [WORD_BITS-1:0] s1_sum_ff, s1_sum_in;
   logic                 s1_last_ff, s1_last_in;
   logic                 s2_valid_ff, s2_valid_in;
   nhbd_entry_type       s2_entry_ff, s2_entry_in;

   logic [NAME_BITS-1:0] folded;
   logic [PROD_BITS-1:0] product;
   logic [OCC_BITS-1:0]  occupancy;
   logic                 accept;

   // Lowercase A to Z, and blank every byte from the first zero byte onwards.
   always_comb begin
      logic       ended;
      logic [7:0] b;
      ended  = 1'b0;
      folded = '0;
      for (int k = 0; k < NAME_BYTES; k++) begin
         b = req_name_bytes[8*k +: 8];
         if (b == 8'h00) begin
            ended = 1'b1;
         end
         if (ended) begin
            b = 8'h00;
         end else if (b >= 8'h41 && b <= 8'h5a) begin
            b = b + 8'h20;
         end
         folded[8*k +: 8] = b;
      end
   end

   // Every request in flight has a queue slot reserved, so pushes are never refused.
   assign occupancy = OCC_BITS'(queue_level) + OCC_BITS'(s1_valid_ff)
                    + OCC_BITS'(s2_valid_ff);
   assign req_stall = (occupancy >= OCC_BITS'(QUEUE_DEPTH));
   assign accept    = req_valid & ~req_stall;

   assign product = PROD_BITS'(s1_sum_ff) * PROD_BITS'(multiplier);

   always_comb begin
      s1_valid_in = accept;
      s1_sum_in   = folded[WORD_BITS-1:0] + folded[NAME_BITS-1 -: WORD_BITS];
      s1_last_in  = req_last_name;
      s2_valid_in = s1_valid_ff;
      s2_entry_in.bucket    = product[BUCKET_LSB +: BUCKET_BITS];
      s2_entry_in.last_name = s1_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_sum_ff   <= s1_sum_in;
      s1_last_ff  <= s1_last_in;
      s2_entry_ff <= s2_entry_in;
   end

   assign push_valid = s2_valid_ff;
   assign push_entry = s2_entry_ff;

endmodule

// ----- design/nhbd_queue.sv -----
module nhbd_queue
   import nhbd_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push_valid,
   input  nhbd_entry_type            push_entry,
   input  logic                      pop,
   output logic                      head_valid,
   output nhbd_entry_type            head_entry,
   output logic [QUEUE_LVL_BITS-1:0] level
);

   nhbd_entry_type              entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_LVL_BITS-1:0]   level_ff, level_in;
   logic                        do_pop;

   assign do_pop = pop & (level_ff != '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      level_in  = level_ff;
      if (push_valid) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                   : wr_ptr_ff + QUEUE_PTR_BITS'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                   : rd_ptr_ff + QUEUE_PTR_BITS'(1);
      end
      if (push_valid && !do_pop) begin
         level_in = level_ff + QUEUE_LVL_BITS'(1);
      end else if (!push_valid && do_pop) begin
         level_in = level_ff - QUEUE_LVL_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign head_valid = (level_ff != '0);
   assign head_entry = entry_ff[rd_ptr_ff];
   assign level      = level_ff;

endmodule

// ----- design/nhbd_back.sv -----
module nhbd_back
   import nhbd_pkg::*;
#(
   parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   head_valid,
   input  nhbd_entry_type         head_entry,
   output logic                   pop,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [BUCKET_BITS-1:0] rsp_bucket,
   output logic [DISP_BITS-1:0]   rsp_dispersion,
   output logic                   rsp_done_res,
   output logic                   rsp_overflow
);

   localparam int SQR_BITS  = 2 * COUNT_BITS;
   localparam int DIFF_BITS = (SQR_BITS > DISP_BITS) ? SQR_BITS : DISP_BITS;

   localparam logic [1:0] ST_FETCH  = 2'd0;
   localparam logic [1:0] ST_UPDATE = 2'd1;
   localparam logic [1:0] ST_SQUARE = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   logic [1:0]            state_ff, state_in;
   nhbd_entry_type        item_ff, item_in;
   logic [BUCKETS-1:0]    valid_ff, valid_in;
   logic [SQ_BITS-1:0]    sq_ff, sq_in;
   logic [COUNT_BITS-1:0] total_ff, total_in;
   logic                  sat_ff, sat_in;
   logic [SQR_BITS-1:0]   t2_ff, t2_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [BUCKET_BITS-1:0] rsp_bucket_ff, rsp_bucket_in;
   logic [DISP_BITS-1:0]   rsp_disp_ff, rsp_disp_in;
   logic                   rsp_done_ff, rsp_done_in;
   logic                   rsp_over_ff, rsp_over_in;

   logic                   out_free;
   logic                   rd_en;
   logic [COUNT_BITS-1:0]  ram_rd_data;
   logic                   wr_en;
   logic [COUNT_BITS-1:0]  count_cur;
   logic [COUNT_BITS-1:0]  count_next;
   logic                   count_full;
   logic [SQ_BITS:0]       sq_sum;
   logic [SQ_BITS-1:0]     sq_after;
   logic                   sq_over;
   logic                   total_full;
   logic [COUNT_BITS-1:0]  total_after;
   logic                   sat_after;
   logic [DIFF_BITS-1:0]   scaled_sq;
   logic [DIFF_BITS-1:0]   t2_ext;
   logic [DIFF_BITS-1:0]   disp_full;

   nhbd_ram #(
      .WIDTH (COUNT_BITS),
      .DEPTH (BUCKETS)
   ) u_counts (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (item_ff.bucket),
      .wr_data (count_next),
      .rd_en   (rd_en),
      .rd_addr (head_entry.bucket),
      .rd_data (ram_rd_data)
   );

   // A new request is fetched only when the output slot is empty or empties this cycle,
   // so every later load of the output register finds it empty.
   assign out_free = ~rsp_valid_ff | ~rsp_stall;
   assign rd_en    = (state_ff == ST_FETCH) & head_valid & out_free;
   assign pop      = rd_en;

   // Counts of buckets untouched since the set began read as zero.
   assign count_cur  = valid_ff[item_ff.bucket] ? ram_rd_data : '0;
   assign count_full = &count_cur;
   assign count_next = count_cur + COUNT_BITS'(1);
   assign wr_en      = (state_ff == ST_UPDATE) & ~count_full;

   assign sq_sum   = {1'b0, sq_ff} + (SQ_BITS+1)'({count_cur, 1'b1});
   assign sq_over  = ~count_full & sq_sum[SQ_BITS];
   assign sq_after = count_full ? sq_ff
                   : (sq_sum[SQ_BITS] ? '1 : sq_sum[SQ_BITS-1:0]);

   assign total_full  = &total_ff;
   assign total_after = total_full ? total_ff : total_ff + COUNT_BITS'(1);
   assign sat_after   = sat_ff | count_full | sq_over | total_full;

   assign scaled_sq = DIFF_BITS'({sq_ff, {BUCKET_BITS{1'b0}}});
   assign t2_ext    = DIFF_BITS'(t2_ff);
   assign disp_full = (scaled_sq > t2_ext) ? scaled_sq - t2_ext : '0;

   always_comb begin
      state_in      = state_ff;
      item_in       = item_ff;
      valid_in      = valid_ff;
      sq_in         = sq_ff;
      total_in      = total_ff;
      sat_in        = sat_ff;
      t2_in         = t2_ff;
      rsp_valid_in  = rsp_valid_ff & rsp_stall;
      rsp_bucket_in = rsp_bucket_ff;
      rsp_disp_in   = rsp_disp_ff;
      rsp_done_in   = rsp_done_ff;
      rsp_over_in   = rsp_over_ff;
      unique case (state_ff)
         ST_FETCH: begin
            if (rd_en) begin
               item_in  = head_entry;
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            valid_in[item_ff.bucket] = 1'b1;
            sq_in    = sq_after;
            total_in = total_after;
            sat_in   = sat_after;
            if (item_ff.last_name) begin
               state_in = ST_SQUARE;
            end else begin
               rsp_valid_in  = 1'b1;
               rsp_bucket_in = item_ff.bucket;
               rsp_disp_in   = '0;
               rsp_done_in   = 1'b0;
               rsp_over_in   = sat_after;
               state_in      = ST_FETCH;
            end
         end
         ST_SQUARE: begin
            t2_in    = SQR_BITS'(total_ff) * SQR_BITS'(total_ff);
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            rsp_valid_in  = 1'b1;
            rsp_bucket_in = item_ff.bucket;
            rsp_disp_in   = disp_full[DISP_BITS-1:0];
            rsp_done_in   = 1'b1;
            rsp_over_in   = sat_ff;
            valid_in      = '0;
            sq_in         = '0;
            total_in      = '0;
            sat_in        = 1'b0;
            state_in      = ST_FETCH;
         end
         default: begin
            state_in = ST_FETCH;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_FETCH;
         valid_ff     <= '0;
         sq_ff        <= '0;
         total_ff     <= '0;
         sat_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         sq_ff        <= sq_in;
         total_ff     <= total_in;
         sat_ff       <= sat_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff       <= item_in;
      t2_ff         <= t2_in;
      rsp_bucket_ff <= rsp_bucket_in;
      rsp_disp_ff   <= rsp_disp_in;
      rsp_done_ff   <= rsp_done_in;
      rsp_over_ff   <= rsp_over_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_bucket     = rsp_bucket_ff;
   assign rsp_dispersion = rsp_disp_ff;
   assign rsp_done_res   = rsp_done_ff;
   assign rsp_overflow   = rsp_over_ff;

endmodule

// ----- design/name_hash_bucket_dispersion.sv -----
// Channel    Direction  Handshake             Payload
// request    in         req_valid/req_stall   req_name_bytes[63:0], req_last_name
// response   out        rsp_valid/rsp_stall   rsp_bucket[6:0], rsp_dispersion[38:0],
//                                             rsp_done_res, rsp_overflow
// csr        in         csr_write             csr_wdata[23:0] (hash multiplier)
//
// In the counting unit, a request not ending a set passes FETCH and UPDATE (counter RAM
// read, then write back); the last of a set also passes SQUARE and FINISH (squaring of
// the total, final subtraction). The read-modify-write holds off the next fetch until
// the prior request is done. The hashing front end registers requests in its s1 and s2
// stages and runs ahead through a 4-entry queue. Reset is synchronous; the bucket counts
// are cleared by per-bucket valid bits, so there is no clearing pass. A stalled response
// holds its register while the front end accepts requests until the queue is full.
module name_hash_bucket_dispersion
   import nhbd_pkg::*;
#(
   parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [NAME_BITS-1:0]   req_name_bytes,
   input  logic                   req_last_name,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [BUCKET_BITS-1:0] rsp_bucket,
   output logic [DISP_BITS-1:0]   rsp_dispersion,
   output logic                   rsp_done_res,
   output logic                   rsp_overflow,
   input  logic                   csr_write,
   input  logic [MULT_BITS-1:0]   csr_wdata
);

   // The hash multiplier. The user must write it only while the block is idle (the block
   // itself does not enforce this), so the front end may use it directly.
   logic [MULT_BITS-1:0] multiplier_ff, multiplier_in;

   logic                      push_valid;
   nhbd_entry_type            push_entry;
   logic                      head_valid;
   nhbd_entry_type            head_entry;
   logic                      pop;
   logic [QUEUE_LVL_BITS-1:0] queue_level;

   assign multiplier_in = csr_write ? csr_wdata : multiplier_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         multiplier_ff <= MULT_RESET;
      end else begin
         multiplier_ff <= multiplier_in;
      end
   end

   // Front end: folds the name, adds its two halves and multiplies to find the bucket.
   nhbd_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_name_bytes (req_name_bytes),
      .req_last_name  (req_last_name),
      .multiplier     (multiplier_ff),
      .queue_level    (queue_level),
      .push_valid     (push_valid),
      .push_entry     (push_entry)
   );

   // Short queue of hashed requests, so each side can stall on its own.
   nhbd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .pop        (pop),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .level      (queue_level)
   );

   // Back end: bucket counters, square sum, total and the dispersion at set end.
   nhbd_back #(
      .COUNT_BITS (COUNT_BITS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .head_valid     (head_valid),
      .head_entry     (head_entry),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_bucket     (rsp_bucket),
      .rsp_dispersion (rsp_dispersion),
      .rsp_done_res   (rsp_done_res),
      .rsp_overflow   (rsp_overflow)
   );

endmodule

// ----- test/tb_name_hash_bucket_dispersion.sv -----
// Self-checking bench for the name hash bucket dispersion block.
//
// Every accepted request is run through a predictor in this module. The predictor folds the
// name to lower case, hashes it into a bucket, updates its own copy of the bucket counts,
// the square sum, the name total and the saturation flag, and computes the dispersion on
// the last name of a set. The expected response is queued, and the monitor compares each
// accepted response with the oldest entry, field by field.
//
// The run has three pressure phases. In the first, the sender idles with odds of 38 in a
// hundred and the receiver stalls in 70. In the second the figures are swapped. In the
// third neither side idles. The multiplier is rewritten only when no response is owed.
// It takes the values zero, all ones, random values, one and the reset value.
//
// With a multiplier of one the bucket can be chosen directly, which allows a built set
// that puts one name in every bucket, so its dispersion must be exactly zero.
module tb_name_hash_bucket_dispersion;
   import nhbd_pkg::*;

   localparam int              TALLY_BITS   = COUNT_BITS_DEFAULT;
   localparam longint unsigned TALLY_MAX    = (64'd1 << TALLY_BITS) - 1;
   localparam longint unsigned SQUARE_MAX   = (64'd1 << SQ_BITS) - 1;
   localparam int              CYCLE_LIMIT  = 2_000_000;
   localparam int              TAIL_CYCLES  = 16;
   localparam int              DIRECTED_LEN = 19;

   typedef struct packed {
      logic [BUCKET_BITS-1:0] bucket;
      logic [DISP_BITS-1:0]   dispersion;
      logic                   done_res;
      logic                   overflow;
   } bucket_report_type;

   typedef struct {
      logic [NAME_BITS-1:0] name;
      logic                 last_name;
      bit                   typed;
      bucket_report_type    report;
   } directed_row_type;

   logic                   clock          = 1'b0;
   logic                   reset          = 1'b1;
   logic                   req_valid      = 1'b0;
   logic                   req_stall;
   logic [NAME_BITS-1:0]   req_name_bytes = '0;
   logic                   req_last_name  = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_stall      = 1'b0;
   logic [BUCKET_BITS-1:0] rsp_bucket;
   logic [DISP_BITS-1:0]   rsp_dispersion;
   logic                   rsp_done_res;
   logic                   rsp_overflow;
   logic                   csr_write      = 1'b0;
   logic [MULT_BITS-1:0]   csr_wdata      = '0;

   // The predictor's copy of the register and of the per-set statistics.
   logic [MULT_BITS-1:0]   multiplier_shadow;
   logic [TALLY_BITS-1:0]  tally [BUCKETS];
   logic [SQ_BITS-1:0]     square_total;
   logic [TALLY_BITS-1:0]  names_seen;
   logic                   set_saturated;

   bucket_report_type      pending_reports [$];
   directed_row_type       directed_rows [DIRECTED_LEN];
   int unsigned            send_idle_pct = 0;
   int unsigned            recv_idle_pct = 0;
   int unsigned            fail_count    = 0;
   int unsigned            cycle_count   = 0;

   always #10 clock = ~clock;

   name_hash_bucket_dispersion #(
      .COUNT_BITS(TALLY_BITS)
   ) uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_name_bytes (req_name_bytes),
      .req_last_name  (req_last_name),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_bucket     (rsp_bucket),
      .rsp_dispersion (rsp_dispersion),
      .rsp_done_res   (rsp_done_res),
      .rsp_overflow   (rsp_overflow),
      .csr_write      (csr_write),
      .csr_wdata      (csr_wdata)
   );

   // ------------------------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------------------------

   function automatic void clear_tallies();
      foreach (tally[i]) tally[i] = '0;
      square_total  = '0;
      names_seen    = '0;
      set_saturated = 1'b0;
   endfunction

   // Upper-case ASCII letters become lower case. The first zero byte ends the name, and
   // everything after it reads as zero whatever was sent.
   function automatic logic [NAME_BITS-1:0] canonical_name(input logic [NAME_BITS-1:0] raw);
      logic [NAME_BITS-1:0] folded;
      logic [7:0]           ch;
      bit                   ended;
      folded = '0;
      ended  = 1'b0;
      for (int k = 0; k < NAME_BYTES; k++) begin
         ch = raw[8*k +: 8];
         if (ch == 8'h00) ended = 1'b1;
         if (ended) ch = 8'h00;
         else if (ch >= 8'h41 && ch <= 8'h5A) ch = ch + 8'h20;
         folded[8*k +: 8] = ch;
      end
      return folded;
   endfunction

   function automatic logic [BUCKET_BITS-1:0] bucket_index(input logic [NAME_BITS-1:0] folded);
      logic [WORD_BITS-1:0] word_sum;
      logic [WORD_BITS-1:0] product;
      word_sum = folded[WORD_BITS-1:0] + folded[NAME_BITS-1:WORD_BITS];
      product  = word_sum * WORD_BITS'(multiplier_shadow);
      return product[BUCKET_LSB +: BUCKET_BITS];
   endfunction

   // Counts one name into the statistics and returns the response that it should produce.
   function automatic bucket_report_type hash_and_tally(input logic [NAME_BITS-1:0] name,
                                                        input logic last_name);
      logic [BUCKET_BITS-1:0] slot;
      longint unsigned        count;
      longint unsigned        grown;
      longint unsigned        scaled;
      longint unsigned        total_sq;
      bucket_report_type      report;
      slot  = bucket_index(canonical_name(name));
      count = tally[slot];
      if (count >= TALLY_MAX) begin
         // A full bucket holds, and its square term is not added.
         set_saturated = 1'b1;
      end else begin
         grown = square_total + 2 * count + 1;
         if (grown > SQUARE_MAX) begin
            grown         = SQUARE_MAX;
            set_saturated = 1'b1;
         end
         square_total = SQ_BITS'(grown);
         tally[slot]  = tally[slot] + 1'b1;
      end
      if (names_seen >= TALLY_MAX) set_saturated = 1'b1;
      else names_seen = names_seen + 1'b1;

      report.bucket     = slot;
      report.dispersion = '0;
      report.done_res   = last_name;
      report.overflow   = set_saturated;
      if (last_name) begin
         scaled   = square_total;
         scaled   = scaled * BUCKETS;
         total_sq = names_seen;
         total_sq = total_sq * total_sq;
         // Saturated figures can leave the difference negative, which reads as zero.
         if (scaled > total_sq) report.dispersion = DISP_BITS'(scaled - total_sq);
         clear_tallies();
      end
      return report;
   endfunction

   // ------------------------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------------------------

   // Presents one request after a random number of idle cycles and holds it until it is
   // accepted. The expected response is queued at the edge that accepts the request. A
   // typed row supplies its own response, but still advances the predictor's state.
   task automatic send_request(input logic [NAME_BITS-1:0] name, input logic last_name,
                               input bit typed, input bucket_report_type typed_report);
      bucket_report_type predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_name_bytes <= name;
      req_last_name  <= last_name;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = hash_and_tally(name, last_name);
      pending_reports.push_back(typed ? typed_report : predicted);
      @(negedge clock);
   endtask

   // Names mostly look like directory entries: upper-case letters, digits and the odd
   // underscore, zero padded to eight bytes. The rest are raw random bytes, names with a
   // zero byte part way through and junk behind it, and one-byte or empty names.
   function automatic logic [NAME_BITS-1:0] random_name();
      logic [NAME_BITS-1:0] name;
      int unsigned          kind;
      int unsigned          length;
      int unsigned          cut;
      name = '0;
      kind = $urandom_range(9);
      if (kind <= 5) begin
         length = $urandom_range(1, NAME_BYTES);
         for (int k = 0; k < length; k++) begin
            case ($urandom_range(4))
               0, 1:    name[8*k +: 8] = 8'(8'h41 + $urandom_range(25));
               2:       name[8*k +: 8] = 8'(8'h30 + $urandom_range(9));
               3:       name[8*k +: 8] = 8'h5F;
               default: name[8*k +: 8] = 8'($urandom_range(1, 255));
            endcase
         end
      end else if (kind <= 7) begin
         name = {$urandom, $urandom};
      end else if (kind == 8) begin
         name = {$urandom, $urandom};
         cut  = $urandom_range(NAME_BYTES - 1);
         name[8*cut +: 8] = 8'h00;
      end else begin
         name[7:0] = 8'($urandom_range(255));
      end
      return name;
   endfunction

   // A run of random names in sets of random length. The final request always closes its
   // set, so that the block is between sets when the multiplier is next rewritten.
   task automatic send_random_run(input int unsigned count);
      for (int unsigned n = 1; n <= count; n++) begin
         send_request(random_name(), (n == count) || ($urandom_range(24) == 0),
                      1'b0, '0);
      end
   endtask

   // With a multiplier of one and an empty upper word, bits 30..24 of the low word are the
   // bucket. Bit 31 is set so that byte 3 is neither zero nor a letter. The low bytes are
   // random but never zero, and folding them cannot carry into byte 3.
   function automatic logic [NAME_BITS-1:0] probe_name(input int unsigned slot);
      return {32'h0, (8'h80 | 8'(slot)), 8'($urandom_range(1, 255)),
              8'($urandom_range(1, 255)), 8'($urandom_range(1, 255))};
   endfunction

   // The multiplier is written only once every response owed has come back, which leaves
   // the block idle and between sets.
   task automatic write_multiplier(input logic [MULT_BITS-1:0] value);
      req_valid <= 1'b0;
      while (pending_reports.size() != 0) @(negedge clock);
      csr_write <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_write         <= 1'b0;
      multiplier_shadow  = value;
   endtask

   // ------------------------------------------------------------------------------------
   // Response side
   // ------------------------------------------------------------------------------------

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   task automatic report_mismatch(input string field, input longint unsigned want,
                                  input longint unsigned got);
      fail_count++;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
   endtask

   task automatic check_report(input bucket_report_type want);
      if (rsp_bucket !== want.bucket)
         report_mismatch("bucket", want.bucket, rsp_bucket);
      if (rsp_dispersion !== want.dispersion)
         report_mismatch("dispersion", want.dispersion, rsp_dispersion);
      if (rsp_done_res !== want.done_res)
         report_mismatch("done_res", want.done_res, rsp_done_res);
      if (rsp_overflow !== want.overflow)
         report_mismatch("overflow", want.overflow, rsp_overflow);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_reports.size() == 0) begin
            fail_count++;
            $display("%0t: response with no request outstanding, bucket %0d", $time,
                     rsp_bucket);
         end else begin
            check_report(pending_reports.pop_front());
         end
      end
   end

   // A hung handshake ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // ------------------------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------------------------

   initial begin
      // The first rows have responses that can be worked out by hand. An empty name hashes
      // to bucket 0 under any multiplier. A name that starts with a zero byte is empty
      // whatever follows. A single name in a set gives 128*1 - 1, and two names in one
      // bucket give 128*4 - 4. The remaining rows probe the edges of case folding, the
      // early end of a name, all-ones and high-bit bytes, and sets of one name.
      directed_rows = '{
         '{64'h0000_0000_0000_0000, 1'b1, 1'b1, '{7'd0, 39'd127, 1'b1, 1'b0}},
         '{64'hFFFF_FFFF_FFFF_FF00, 1'b0, 1'b1, '{7'd0, 39'd0,   1'b0, 1'b0}},
         '{64'h0000_0000_0000_0000, 1'b1, 1'b1, '{7'd0, 39'd508, 1'b1, 1'b0}},
         '{64'h0000_0000_0000_0041, 1'b0, 1'b0, '0},
         '{64'h0000_0000_0000_0061, 1'b0, 1'b0, '0},
         '{64'h0000_0000_0000_005A, 1'b0, 1'b0, '0},
         '{64'h0000_0000_0000_007A, 1'b0, 1'b0, '0},
         '{64'h0000_0000_0000_0040, 1'b0, 1'b0, '0},
         '{64'h0000_0000_0000_005B, 1'b0, 1'b0, '0},
         '{64'h5A5A_5A5A_5A5A_5A5A, 1'b0, 1'b0, '0},
         '{64'h7A7A_7A7A_7A7A_7A7A, 1'b0, 1'b0, '0},
         '{64'h4142_4344_0045_4647, 1'b0, 1'b0, '0},
         '{64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, '0},
         '{64'h8080_8080_8080_8080, 1'b0, 1'b0, '0},
         '{64'h0000_0001_0000_0001, 1'b0, 1'b0, '0},
         '{64'h3130_5041_4D45_474E, 1'b1, 1'b0, '0},
         '{64'h0000_0000_0000_4D41, 1'b1, 1'b0, '0},
         '{64'h0000_0000_0000_4D61, 1'b1, 1'b0, '0},
         '{64'h7F7F_7F7F_7F7F_7F7F, 1'b1, 1'b0, '0}
      };
      multiplier_shadow = MULT_RESET;
      clear_tallies();

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // First phase: a sender that idles now and then and a receiver that mostly stalls.
      send_idle_pct = 38;
      recv_idle_pct = 70;
      foreach (directed_rows[i]) begin
         send_request(directed_rows[i].name, directed_rows[i].last_name,
                      directed_rows[i].typed, directed_rows[i].report);
      end
      send_random_run(300);
      // A zero multiplier sends every name to bucket 0.
      write_multiplier('0);
      send_random_run(150);

      // Second phase: the pressure is the other way round.
      send_idle_pct = 70;
      recv_idle_pct = 38;
      write_multiplier('1);
      send_random_run(300);
      write_multiplier(MULT_BITS'($urandom));
      send_random_run(300);

      // Third phase: back to back in both directions.
      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_multiplier(MULT_BITS'(1));
      // One name per bucket is a perfectly even spread, so the dispersion is zero.
      for (int unsigned k = 0; k < BUCKETS; k++) begin
         send_request(probe_name(k), k == BUCKETS - 1, 1'b1,
                      bucket_report_type'{BUCKET_BITS'(k), DISP_BITS'(0),
                                          k == BUCKETS - 1, 1'b0});
      end
      write_multiplier(MULT_BITS'($urandom));
      send_random_run(300);
      write_multiplier(MULT_RESET);
      send_random_run(200);

      req_valid <= 1'b0;
      while (pending_reports.size() != 0) @(negedge clock);
      // A short tail catches any response that should not be there.
      repeat (TAIL_CYCLES) @(negedge clock);
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
